// File: sv/lqs_pkg.sv
// Shared types, codes and constants of the linear queue with search.
package lqs_pkg;

	// Sizes fixed by the request and result formats
	localparam int LQS_DEPTH  = 32;
	localparam int DATA_W     = 32;
	localparam int CAP_W      = 6;
	localparam int POS_W      = 6;
	localparam int REQ_W      = 2;
	localparam int STAT_W     = 2;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(20);

	// Request kinds
	typedef enum logic [REQ_W-1:0] {
		REQ_ENQ     = 2'd0,
		REQ_DEQ     = 2'd1,
		REQ_SEARCH  = 2'd2,
		REQ_REPLACE = 2'd3
	} lqs_req_t;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_OVERFLOW = 2'd1,
		STAT_EMPTY    = 2'd2,
		STAT_NOTFOUND = 2'd3
	} lqs_stat_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DEQ_WAIT,
		ST_SCAN,
		ST_DONE
	} lqs_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic latch;      // capture the incoming request
		logic enq_write;  // write the word at the tail, move the tail
		logic res_ovf;    // result: overflow
		logic res_empty;  // result: queue empty
		logic deq_issue;  // read the head slot
		logic deq_pop;    // take the head word, move the head
		logic scan_start; // read the head slot, pointer to head
		logic scan_next;  // advance the scan pointer
		logic scan_hit;   // first match found at the pointer
		logic scan_miss;  // tail passed without a match
		logic out_load;   // move the result into the output register
	} lqs_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		lqs_req_t req;
		logic     full;
		logic     empty;
		logic     match;
		logic     at_tail;
		logic     out_free;
	} lqs_sts_t;

endpackage

// File: sv/lqs_ifs.sv
// Channel interfaces: request, result and configuration.

interface lqs_req_if import lqs_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [REQ_W-1:0]         req_type;
	logic signed [DATA_W-1:0] value;
	logic signed [DATA_W-1:0] new_value;

	modport source (output valid, req_type, value, new_value, input ready);
	modport sink   (input valid, req_type, value, new_value, output ready);
endinterface

interface lqs_rsp_if import lqs_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [STAT_W-1:0]        status;
	logic signed [DATA_W-1:0] read_data;
	logic [POS_W-1:0]         position;
	logic                     is_empty;
	logic                     is_full;

	modport source (output valid, status, read_data, position, is_empty, is_full,
		input ready);
	modport sink   (input valid, status, read_data, position, is_empty, is_full,
		output ready);
endinterface

interface lqs_cfg_if import lqs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// File: sv/lqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/lqs_ctrl.sv
// Request sequencer: decides the steps of each request from datapath status.
module lqs_ctrl import lqs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  lqs_sts_t sts,
	output lqs_cmd_t cmd
);

	lqs_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (sts.req)
					REQ_ENQ: state_d = ST_DONE;
					REQ_DEQ: state_d = sts.empty ? ST_DONE : ST_DEQ_WAIT;
					default: state_d = sts.empty ? ST_DONE : ST_SCAN;
				endcase
			end
			ST_DEQ_WAIT: state_d = ST_DONE;
			ST_SCAN: begin
				if (sts.match || sts.at_tail) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
			end
			ST_EXEC: begin
				case (sts.req)
					REQ_ENQ: begin
						cmd.res_ovf   = sts.full;
						cmd.enq_write = !sts.full;
					end
					REQ_DEQ: begin
						cmd.res_empty = sts.empty;
						cmd.deq_issue = !sts.empty;
					end
					default: begin
						cmd.res_empty  = sts.empty;
						cmd.scan_start = !sts.empty;
					end
				endcase
			end
			ST_DEQ_WAIT: cmd.deq_pop = 1'b1;
			ST_SCAN: begin
				cmd.scan_hit  = sts.match;
				cmd.scan_miss = !sts.match && sts.at_tail;
				cmd.scan_next = !sts.match && !sts.at_tail;
			end
			ST_DONE: cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

endmodule

// File: sv/lqs_dp.sv
// Queue datapath: slot store, indices, scan pointer and result registers.
module lqs_dp import lqs_pkg::*; #(
	parameter int DEPTH = LQS_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// request payload
	input  logic [REQ_W-1:0]         req_type,
	input  logic signed [DATA_W-1:0] value,
	input  logic signed [DATA_W-1:0] new_value,
	// configuration
	input  logic                     cfg_valid,
	input  logic [CAP_W-1:0]         cfg_data,
	// control
	input  lqs_cmd_t                 cmd,
	output lqs_sts_t                 sts,
	// result channel
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	output logic [STAT_W-1:0]        rsp_status,
	output logic signed [DATA_W-1:0] rsp_read_data,
	output logic [POS_W-1:0]         rsp_position,
	output logic                     rsp_is_empty,
	output logic                     rsp_is_full
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = ((IW > CAP_W) ? IW : CAP_W) + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic [CAP_W-1:0]  cap_q;
	logic [IW-1:0]     head_q, tail_q, ptr_q;
	logic              empty_q;
	lqs_req_t          req_q;
	logic [DATA_W-1:0] value_q, new_value_q;
	lqs_stat_t         status_q;
	logic [DATA_W-1:0] data_q;
	logic [POS_W-1:0]  pos_q;
	logic              out_valid_q;

	logic [CW-1:0]     cap_x, cap_eff;
	logic              full;
	logic [IW-1:0]     tail_inc, ptr_inc;
	logic [IW:0]       pos_full;
	logic              we;
	logic [IW-1:0]     waddr, raddr;
	logic [DATA_W-1:0] wdata, rdata;
	logic              re;

	// Effective capacity, clamped to one..DEPTH, and the full test
	always_comb begin
		cap_x   = CW'(cap_q);
		cap_eff = cap_x;
		if (cap_x == '0) cap_eff = CW'(1);
		if (cap_x > DEPTH_C) cap_eff = DEPTH_C;
		full = !empty_q && (CW'(tail_q) >= cap_eff - CW'(1));
	end

	assign tail_inc = tail_q + IW'(1);
	assign ptr_inc  = ptr_q + IW'(1);
	assign pos_full = {1'b0, ptr_q} + (IW+1)'(1);

	// Store ports: enqueue and replace write, head or next pointer read
	assign we    = cmd.enq_write || (cmd.scan_hit && req_q == REQ_REPLACE);
	assign waddr = cmd.enq_write ? (empty_q ? '0 : tail_inc) : ptr_q;
	assign wdata = cmd.enq_write ? value_q : new_value_q;
	assign re    = cmd.deq_issue || cmd.scan_start || cmd.scan_next;
	assign raddr = (cmd.deq_issue || cmd.scan_start) ? head_q : ptr_inc;

	lqs_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	// Head, tail and empty flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else if (cmd.enq_write) begin
			if (empty_q) begin
				head_q  <= '0;
				tail_q  <= '0;
				empty_q <= 1'b0;
			end else begin
				tail_q <= tail_inc;
			end
		end else if (cmd.deq_pop) begin
			if (head_q >= tail_q) begin
				head_q  <= '0;
				tail_q  <= '0;
				empty_q <= 1'b1;
			end else begin
				head_q <= head_q + IW'(1);
			end
		end
	end

	// Request capture and scan pointer
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q       <= lqs_req_t'(req_type);
			value_q     <= value;
			new_value_q <= new_value;
		end
		if (cmd.scan_start) begin
			ptr_q <= head_q;
		end else if (cmd.scan_next) begin
			ptr_q <= ptr_inc;
		end
	end

	// Result being built
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			status_q <= STAT_OK;
			data_q   <= '0;
			pos_q    <= '0;
		end
		if (cmd.res_ovf) status_q <= STAT_OVERFLOW;
		if (cmd.res_empty) begin
			status_q <= STAT_EMPTY;
			data_q   <= (req_q == REQ_DEQ) ? '1 : '0;
		end
		if (cmd.deq_pop) data_q <= rdata;
		if (cmd.scan_hit && req_q == REQ_SEARCH) pos_q <= POS_W'(pos_full);
		if (cmd.scan_miss) status_q <= STAT_NOTFOUND;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_status    <= status_q;
			rsp_read_data <= data_q;
			rsp_position  <= pos_q;
			rsp_is_empty  <= empty_q;
			rsp_is_full   <= full;
		end
	end

	assign rsp_valid = out_valid_q;

	// Status to the controller
	always_comb begin
		sts.req      = req_q;
		sts.full     = full;
		sts.empty    = empty_q;
		sts.match    = (rdata == value_q);
		sts.at_tail  = (ptr_q == tail_q);
		sts.out_free = !out_valid_q || rsp_ready;
	end

`ifndef ASSERT_OFF
	a_head_le_tail: assert property (@(posedge clk) disable iff (!arst_n)
		!empty_q |-> head_q <= tail_q)
		else $error("head index beyond tail");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> (head_q == '0 && tail_q == '0))
		else $error("empty queue with non-zero indices");

	a_enq_fills: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enq_write |=> !empty_q)
		else $error("queue still empty after enqueue");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || rsp_ready))
		else $error("result loaded over an unread result");
`endif

endmodule

// File: sv/linear_queue_with_search_core.sv
// Top level of the linear queue with search: controller, datapath, channels.
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    req_type, value, new_value
//  rsp      out  valid/ready    status, read_data, position, is_empty, is_full
//  cfg      in   valid/ready    data (capacity)
//
// Enqueue passes through EXEC and DONE after acceptance, dequeue through
// EXEC, DEQ_WAIT and DONE; search and replace stay in SCAN between EXEC and
// DONE while one comparator walks at most DEPTH slots, one read per cycle.
// One request is in progress at a time; a new one is accepted while the last
// result still waits in the output register.
// Reset (arst_n, asynchronous) empties the queue and sets capacity to 20.
// cfg is always ready.
module linear_queue_with_search_core import lqs_pkg::*; #(
	parameter int DEPTH = LQS_DEPTH
) (
	input logic      clk,
	input logic      arst_n,
	lqs_req_if.sink   req,
	lqs_rsp_if.source rsp,
	lqs_cfg_if.sink   cfg
);

	lqs_cmd_t cmd;
	lqs_sts_t sts;

	// Capacity writes are taken at any time
	assign cfg.ready = 1'b1;

	// Sequencer
	lqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath
	lqs_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_type      (req.req_type),
		.value         (req.value),
		.new_value     (req.new_value),
		.cfg_valid     (cfg.valid),
		.cfg_data      (cfg.data),
		.cmd           (cmd),
		.sts           (sts),
		.rsp_valid     (rsp.valid),
		.rsp_ready     (rsp.ready),
		.rsp_status    (rsp.status),
		.rsp_read_data (rsp.read_data),
		.rsp_position  (rsp.position),
		.rsp_is_empty  (rsp.is_empty),
		.rsp_is_full   (rsp.is_full)
	);

endmodule

// File: bench/tb_linear_queue_with_search_core.sv
// Testbench for the linear queue with search: directed and random requests, scoreboarded.
`timescale 1ns / 1ps

module tb_linear_queue_with_search_core;
	import lqs_pkg::*;

	localparam int CLK_PERIOD  = 10;
	localparam int STALL_LIMIT = 2000;
	localparam int RSP_HOLD    = 300;

	localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

	typedef struct {
		lqs_stat_t                status;
		logic signed [DATA_W-1:0] read_data;
		logic [POS_W-1:0]         position;
		logic                     is_empty;
		logic                     is_full;
	} queue_outcome_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	lqs_req_if req_ch ();
	lqs_rsp_if rsp_ch ();
	lqs_cfg_if cfg_ch ();

	linear_queue_with_search_core #(
		.DEPTH (LQS_DEPTH)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Shadow copy of the queue
	logic signed [DATA_W-1:0] mdl_slots [LQS_DEPTH];
	int unsigned              mdl_head;
	int unsigned              mdl_tail;
	bit                       mdl_empty;
	logic [CAP_W-1:0]         mdl_cap;

	queue_outcome_t outcome_fifo [$];
	int             n_errors = 0;
	bit             gaps_on  = 1'b1;
	int             rsp_hold = 0;

	task automatic log_error(string msg);
		$display("ERROR @%0t: %s", $time, msg);
		n_errors++;
	endtask

	// Tail at or past the usable end; capacity 0 counts as 1, above DEPTH as DEPTH
	function automatic bit model_full();
		int unsigned lim;
		lim = mdl_cap;
		if (lim == 0) lim = 1;
		if (lim > LQS_DEPTH) lim = LQS_DEPTH;
		return !mdl_empty && mdl_tail >= lim - 1;
	endfunction

	// Apply one request to the shadow queue and return the result it must give
	function automatic queue_outcome_t queue_op_outcome(lqs_req_t kind,
			logic signed [DATA_W-1:0] key, logic signed [DATA_W-1:0] repl);
		queue_outcome_t o;
		int unsigned    i;
		int unsigned    hit;
		o.status    = STAT_OK;
		o.read_data = '0;
		o.position  = '0;
		hit         = LQS_DEPTH;
		case (kind)
			REQ_ENQ: begin
				if (model_full()) begin
					o.status = STAT_OVERFLOW;
				end else if (mdl_empty) begin
					mdl_head     = 0;
					mdl_tail     = 0;
					mdl_empty    = 1'b0;
					mdl_slots[0] = key;
				end else begin
					mdl_tail++;
					if (mdl_tail < LQS_DEPTH) mdl_slots[mdl_tail] = key;
				end
			end
			REQ_DEQ: begin
				if (mdl_empty) begin
					o.status    = STAT_EMPTY;
					o.read_data = -1;
				end else begin
					o.read_data = mdl_slots[mdl_head];
					// last word out puts both indices back to zero
					if (mdl_head >= mdl_tail) begin
						mdl_head  = 0;
						mdl_tail  = 0;
						mdl_empty = 1'b1;
					end else begin
						mdl_head++;
					end
				end
			end
			default: begin
				if (mdl_empty) begin
					o.status = STAT_EMPTY;
				end else begin
					for (i = mdl_head; i <= mdl_tail && i < LQS_DEPTH; i++)
						if (hit == LQS_DEPTH && mdl_slots[i] == key) hit = i;
					if (hit == LQS_DEPTH) o.status = STAT_NOTFOUND;
					else if (kind == REQ_SEARCH) o.position = POS_W'(hit + 1);
					else mdl_slots[hit] = repl;
				end
			end
		endcase
		o.is_empty = mdl_empty;
		o.is_full  = model_full();
		return o;
	endfunction

	// Mostly no gap, some short gaps, a few long ones
	function automatic int pick_gap();
		if (!gaps_on) return 0;
		case ($urandom_range(0, 19))
			0:             return $urandom_range(15, 60);
			1, 2, 3, 4, 5: return $urandom_range(1, 4);
			default:       return 0;
		endcase
	endfunction

	// Extremes and a small pool of values so that duplicates occur
	function automatic logic signed [DATA_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return WORD_MIN;
			1:       return WORD_MAX;
			2:       return 0;
			3:       return -1;
			4, 5:    return $urandom_range(0, 7);
			default: return $urandom;
		endcase
	endfunction

	// Key for search or replace: usually a word now in the queue
	function automatic logic signed [DATA_W-1:0] pick_key();
		if (!mdl_empty && $urandom_range(0, 9) < 7)
			return mdl_slots[$urandom_range(mdl_tail, mdl_head)];
		return pick_word();
	endfunction

	// Offer one request, wait for its acceptance, record the predicted result
	task automatic send_req(lqs_req_t kind, logic signed [DATA_W-1:0] key,
			logic signed [DATA_W-1:0] repl);
		int gap;
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= kind;
		req_ch.value     <= key;
		req_ch.new_value <= repl;
		do @(posedge clk); while (!req_ch.ready);
		outcome_fifo.push_back(queue_op_outcome(kind, key, repl));
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Weighted towards dequeue once full so the linear queue drains and restarts
	task automatic send_random_op();
		int unsigned roll;
		lqs_req_t    kind;
		roll = $urandom_range(0, 99);
		if (model_full()) begin
			if (roll < 15) kind = REQ_ENQ;
			else if (roll < 70) kind = REQ_DEQ;
			else if (roll < 85) kind = REQ_SEARCH;
			else kind = REQ_REPLACE;
		end else begin
			if (roll < 45) kind = REQ_ENQ;
			else if (roll < 70) kind = REQ_DEQ;
			else if (roll < 88) kind = REQ_SEARCH;
			else kind = REQ_REPLACE;
		end
		if (kind == REQ_ENQ) send_req(kind, pick_word(), $urandom);
		else send_req(kind, pick_key(), $urandom);
	endtask

	// Stop offering and wait for every outstanding result, then idle a while
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (outcome_fifo.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_capacity(logic [CAP_W-1:0] cap);
		drain_results();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= cap;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		mdl_cap = cap;
	endtask

	// Dequeue, search and replace on the queue straight after reset
	task automatic test_empty_queue();
		send_req(REQ_DEQ, 0, 0);
		send_req(REQ_SEARCH, 0, 0);
		send_req(REQ_REPLACE, 0, -1);
	endtask

	// Extreme words, first-match rules, replace, and draining to empty
	task automatic test_basic_requests();
		send_req(REQ_ENQ, WORD_MIN, 0);
		send_req(REQ_ENQ, WORD_MAX, 0);
		send_req(REQ_ENQ, 0, WORD_MAX);
		send_req(REQ_ENQ, -1, 0);
		send_req(REQ_ENQ, 32'sh5555_5555, 0);
		send_req(REQ_ENQ, WORD_MAX, 0);
		send_req(REQ_SEARCH, WORD_MAX, 0);
		send_req(REQ_SEARCH, 32'sh5555_5555, 0);
		send_req(REQ_SEARCH, 12345, 0);
		send_req(REQ_REPLACE, WORD_MAX, 32'shAAAA_AAAA);
		send_req(REQ_SEARCH, WORD_MAX, 0);
		send_req(REQ_SEARCH, 32'shAAAA_AAAA, 0);
		send_req(REQ_REPLACE, 777, WORD_MIN);
		repeat (6) send_req(REQ_DEQ, 0, 0);
		send_req(REQ_DEQ, 0, 0);
		send_req(REQ_ENQ, 32'sh0F0F_0F0F, 0);
		send_req(REQ_DEQ, 0, 0);
	endtask

	// Capacity zero, one, two and above the store depth
	task automatic test_capacity_limits();
		int k;
		set_capacity(6'd0);
		send_req(REQ_ENQ, 3, 0);
		send_req(REQ_ENQ, 4, 0);
		send_req(REQ_SEARCH, 3, 0);
		send_req(REQ_DEQ, 0, 0);
		set_capacity(6'd1);
		send_req(REQ_ENQ, 5, 0);
		send_req(REQ_ENQ, 6, 0);
		send_req(REQ_DEQ, 0, 0);
		set_capacity(6'd2);
		repeat (3) send_req(REQ_ENQ, pick_word(), 0);
		repeat (2) send_req(REQ_DEQ, 0, 0);
		set_capacity(6'd63);
		for (k = 0; k < LQS_DEPTH + 1; k++) send_req(REQ_ENQ, 32'sh1000_0000 + k, 0);
		// match in the last slot gives position 32
		send_req(REQ_SEARCH, mdl_slots[LQS_DEPTH - 1], 0);
		repeat (3) send_req(REQ_DEQ, 0, 0);
		// freed head slots are not reused
		send_req(REQ_ENQ, 9, 0);
		send_req(REQ_SEARCH, mdl_slots[mdl_head], 0);
		send_req(REQ_REPLACE, mdl_slots[LQS_DEPTH - 1], WORD_MIN);
		send_req(REQ_SEARCH, WORD_MIN, 0);
		repeat (LQS_DEPTH - 3) send_req(REQ_DEQ, 0, 0);
		send_req(REQ_ENQ, 10, 0);
		send_req(REQ_DEQ, 0, 0);
	endtask

	// Capacity dropped below the tail while words are queued
	task automatic test_capacity_lowered();
		int k;
		set_capacity(CAP_RESET);
		for (k = 0; k < 12; k++) send_req(REQ_ENQ, 32'sh2000_0000 + k, 0);
		set_capacity(6'd5);
		send_req(REQ_ENQ, 1, 0);
		send_req(REQ_SEARCH, mdl_slots[mdl_head + 7], 0);
		send_req(REQ_REPLACE, mdl_slots[mdl_head + 9], -5);
		repeat (12) send_req(REQ_DEQ, 0, 0);
		repeat (6) send_req(REQ_ENQ, pick_word(), 0);
		set_capacity(CAP_RESET);
		send_req(REQ_ENQ, 2, 0);
	endtask

	// Receiver holds off long enough for the block to stall its input
	task automatic test_output_stall();
		gaps_on  = 1'b0;
		rsp_hold = RSP_HOLD;
		repeat (24) send_random_op();
		gaps_on = 1'b1;
		drain_results();
	endtask

	// Sender stops until every result is back, then resumes
	task automatic test_sender_pause();
		repeat (10) send_random_op();
		drain_results();
		repeat (10) send_random_op();
	endtask

	// Random phases over a spread of capacities, one phase without gaps
	task automatic test_random_traffic();
		logic [CAP_W-1:0] caps [6];
		int               p;
		caps = '{6'd20, 6'd32, 6'd1, 6'd63, 6'd8, 6'd0};
		for (p = 0; p < 6; p++) begin
			if (p == 4) set_capacity(CAP_W'($urandom_range(2, 31)));
			else set_capacity(caps[p]);
			gaps_on = (p != 1);
			repeat (200) send_random_op();
		end
		gaps_on = 1'b1;
	endtask

	// Result receiver: random stalls plus the long hold-off on request
	initial begin : rsp_drive
		int gap_left;
		gap_left = 0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_hold > 0) begin
				rsp_ch.ready <= 1'b0;
				rsp_hold--;
			end else if (gap_left > 0) begin
				rsp_ch.ready <= 1'b0;
				gap_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) gap_left = pick_gap();
			end
		end
	end

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin : check_results
		queue_outcome_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (outcome_fifo.size() == 0) begin
				log_error("result with no request outstanding");
			end else begin
				want = outcome_fifo.pop_front();
				if (rsp_ch.status !== want.status)
					log_error($sformatf("status got %0d want %0d",
						rsp_ch.status, want.status));
				if (rsp_ch.read_data !== want.read_data)
					log_error($sformatf("read_data got %0d want %0d",
						rsp_ch.read_data, want.read_data));
				if (rsp_ch.position !== want.position)
					log_error($sformatf("position got %0d want %0d",
						rsp_ch.position, want.position));
				if (rsp_ch.is_empty !== want.is_empty)
					log_error($sformatf("is_empty got %b want %b",
						rsp_ch.is_empty, want.is_empty));
				if (rsp_ch.is_full !== want.is_full)
					log_error($sformatf("is_full got %b want %b",
						rsp_ch.is_full, want.is_full));
			end
		end
	end

	// Ends the run if no channel moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		int k;
		req_ch.valid     <= 1'b0;
		req_ch.req_type  <= REQ_ENQ;
		req_ch.value     <= '0;
		req_ch.new_value <= '0;
		cfg_ch.valid     <= 1'b0;
		cfg_ch.data      <= CAP_RESET;
		for (k = 0; k < LQS_DEPTH; k++) mdl_slots[k] = '0;
		mdl_head  = 0;
		mdl_tail  = 0;
		mdl_empty = 1'b1;
		mdl_cap   = CAP_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_basic_requests();
		test_capacity_limits();
		test_capacity_lowered();
		test_output_stall();
		test_sender_pause();
		test_random_traffic();

		drain_results();
		if (outcome_fifo.size() != 0) log_error("results still outstanding at the end");
		if (n_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
